// ===== rtl/qmcf_pkg.sv =====
// Shared types, constants and the microcode program of the quartic minimum block.
// Depends on nothing; every other file imports it.
package qmcf_pkg;

  typedef logic signed [63:0] word_t;

  localparam logic [63:0] MAXV_U = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BAD_LEAD = 2'd1;
  localparam logic [1:0] STAT_NEG_DISC = 2'd2;
  localparam logic [1:0] STAT_SAT      = 2'd3;

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_SHR, OP_MULI, OP_NEG, OP_MIN0,
    OP_FMUL, OP_FDIV, OP_DIV3, OP_SQRT, OP_CBRT,
    OP_JFLAT, OP_JNEG, OP_JMP, OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] rd;
    logic [4:0] ra;
    logic [4:0] rb;
    logic [7:0] imm;
  } uop_t;

  typedef struct packed {
    logic signed [31:0] coef0;
    logic signed [31:0] coef1;
    logic signed [31:0] coef2;
    logic signed [31:0] coef3;
    logic signed [31:0] coef4;
    logic               bad;
  } item_t;

  // Register file slots
  localparam logic [4:0] R_A0 = 5'd0,  R_A1 = 5'd1,  R_A2 = 5'd2,  R_A3 = 5'd3;
  localparam logic [4:0] R_A4 = 5'd4,  R_U  = 5'd5,  R_V  = 5'd6,  R_W  = 5'd7;
  localparam logic [4:0] R_U2 = 5'd8,  R_U3 = 5'd9,  R_U4 = 5'd10, R_B0 = 5'd11;
  localparam logic [4:0] R_B1 = 5'd12, R_B2 = 5'd13, R_SH = 5'd14, R_T0 = 5'd15;
  localparam logic [4:0] R_T1 = 5'd16, R_T2 = 5'd17, R_T3 = 5'd18, R_T4 = 5'd19;
  localparam logic [4:0] R_T5 = 5'd20, R_T6 = 5'd21, R_T7 = 5'd22, R_INF = 5'd23;
  localparam logic [4:0] R_LOC = 5'd24, R_VAL = 5'd25;

  localparam logic [6:0] PC_SYM  = 7'd51;
  localparam logic [6:0] PC_TAIL = 7'd61;
  localparam logic [6:0] PC_LAST = 7'd64;

  function automatic uop_t mk_uop(input op_t op, input logic [4:0] rd,
                                  input logic [4:0] ra, input logic [4:0] rb,
                                  input logic [7:0] imm);
    uop_t u;
    u.op = op; u.rd = rd; u.ra = ra; u.rb = rb; u.imm = imm;
    return u;
  endfunction

  function automatic uop_t uop_rom(input logic [6:0] pc);
    uop_t u;
    case (pc)
      // depressed-form terms
      7'd0:  u = mk_uop(OP_FDIV, R_U,  R_A3, R_A4, 8'd0);
      7'd1:  u = mk_uop(OP_FDIV, R_V,  R_A2, R_A4, 8'd0);
      7'd2:  u = mk_uop(OP_FDIV, R_W,  R_A1, R_A4, 8'd0);
      7'd3:  u = mk_uop(OP_FMUL, R_U2, R_U,  R_U,  8'd0);
      7'd4:  u = mk_uop(OP_FMUL, R_U3, R_U2, R_U,  8'd0);
      7'd5:  u = mk_uop(OP_FMUL, R_U4, R_U2, R_U2, 8'd0);
      7'd6:  u = mk_uop(OP_DIV3, R_T0, R_V,  R_V,  8'd0);
      7'd7:  u = mk_uop(OP_SHR,  R_T1, R_U2, R_U2, 8'd3);
      7'd8:  u = mk_uop(OP_SUB,  R_B2, R_T0, R_T1, 8'd0);
      7'd9:  u = mk_uop(OP_SHR,  R_T0, R_W,  R_W,  8'd1);
      7'd10: u = mk_uop(OP_SHR,  R_T1, R_U3, R_U3, 8'd4);
      7'd11: u = mk_uop(OP_ADD,  R_T0, R_T0, R_T1, 8'd0);
      7'd12: u = mk_uop(OP_FMUL, R_T1, R_V,  R_U,  8'd0);
      7'd13: u = mk_uop(OP_SHR,  R_T1, R_T1, R_T1, 8'd2);
      7'd14: u = mk_uop(OP_SUB,  R_B1, R_T0, R_T1, 8'd0);
      7'd15: u = mk_uop(OP_FMUL, R_T0, R_V,  R_U2, 8'd0);
      7'd16: u = mk_uop(OP_SHR,  R_T0, R_T0, R_T0, 8'd4);
      7'd17: u = mk_uop(OP_FMUL, R_T1, R_W,  R_U,  8'd0);
      7'd18: u = mk_uop(OP_SHR,  R_T1, R_T1, R_T1, 8'd2);
      7'd19: u = mk_uop(OP_SUB,  R_T0, R_T0, R_T1, 8'd0);
      7'd20: u = mk_uop(OP_MULI, R_T1, R_U4, R_U4, 8'd3);
      7'd21: u = mk_uop(OP_SHR,  R_T1, R_T1, R_T1, 8'd8);
      7'd22: u = mk_uop(OP_SUB,  R_T0, R_T0, R_T1, 8'd0);
      7'd23: u = mk_uop(OP_FMUL, R_B0, R_A4, R_T0, 8'd0);
      7'd24: u = mk_uop(OP_SHR,  R_SH, R_U,  R_U,  8'd2);
      7'd25: u = mk_uop(OP_JFLAT, R_T0, R_B1, R_B1, {1'b0, PC_SYM});
      // cube-root branch
      7'd26: u = mk_uop(OP_FMUL, R_T0, R_B2, R_B2, 8'd0);
      7'd27: u = mk_uop(OP_FMUL, R_T1, R_B1, R_B1, 8'd0);
      7'd28: u = mk_uop(OP_FMUL, R_T2, R_T0, R_B2, 8'd0);
      7'd29: u = mk_uop(OP_MULI, R_T3, R_T2, R_T2, 8'd2);
      7'd30: u = mk_uop(OP_ADD,  R_T3, R_T1, R_T3, 8'd0);
      7'd31: u = mk_uop(OP_FMUL, R_T3, R_T1, R_T3, 8'd0);
      7'd32: u = mk_uop(OP_JNEG, R_T3, R_T3, R_T3, 8'd0);
      7'd33: u = mk_uop(OP_SQRT, R_T4, R_T3, R_T3, 8'd0);
      7'd34: u = mk_uop(OP_ADD,  R_T5, R_T1, R_T2, 8'd0);
      7'd35: u = mk_uop(OP_ADD,  R_T5, R_T5, R_T4, 8'd0);
      7'd36: u = mk_uop(OP_CBRT, R_T5, R_T5, R_T5, 8'd0);
      7'd37: u = mk_uop(OP_FDIV, R_T6, R_T0, R_T5, 8'd0);
      7'd38: u = mk_uop(OP_ADD,  R_T6, R_T5, R_T6, 8'd0);
      7'd39: u = mk_uop(OP_ADD,  R_T6, R_T6, R_B2, 8'd0);
      7'd40: u = mk_uop(OP_FDIV, R_T7, R_B1, R_T6, 8'd0);
      7'd41: u = mk_uop(OP_NEG,  R_T7, R_T7, R_T7, 8'd0);
      7'd42: u = mk_uop(OP_SUB,  R_LOC, R_T7, R_SH, 8'd0);
      7'd43: u = mk_uop(OP_SUB,  R_T0, R_T6, R_B2, 8'd0);
      7'd44: u = mk_uop(OP_MULI, R_T1, R_B2, R_B2, 8'd3);
      7'd45: u = mk_uop(OP_SUB,  R_T1, R_T6, R_T1, 8'd0);
      7'd46: u = mk_uop(OP_FMUL, R_T0, R_T0, R_T1, 8'd0);
      7'd47: u = mk_uop(OP_MULI, R_T0, R_T0, R_T0, 8'd3);
      7'd48: u = mk_uop(OP_SHR,  R_T0, R_T0, R_T0, 8'd2);
      7'd49: u = mk_uop(OP_NEG,  R_INF, R_T0, R_T0, 8'd0);
      7'd50: u = mk_uop(OP_JMP,  R_T0, R_T0, R_T0, {1'b0, PC_TAIL});
      // symmetric branch
      7'd51: u = mk_uop(OP_MIN0, R_T0, R_B2, R_B2, 8'd0);
      7'd52: u = mk_uop(OP_FMUL, R_T1, R_T0, R_T0, 8'd0);
      7'd53: u = mk_uop(OP_MULI, R_T1, R_T1, R_T1, 8'd9);
      7'd54: u = mk_uop(OP_SHR,  R_T1, R_T1, R_T1, 8'd2);
      7'd55: u = mk_uop(OP_NEG,  R_INF, R_T1, R_T1, 8'd0);
      7'd56: u = mk_uop(OP_MULI, R_T2, R_T0, R_T0, 8'd3);
      7'd57: u = mk_uop(OP_SHR,  R_T2, R_T2, R_T2, 8'd1);
      7'd58: u = mk_uop(OP_NEG,  R_T2, R_T2, R_T2, 8'd0);
      7'd59: u = mk_uop(OP_SQRT, R_T2, R_T2, R_T2, 8'd0);
      7'd60: u = mk_uop(OP_SUB,  R_LOC, R_T2, R_SH, 8'd0);
      // value at the minimum
      7'd61: u = mk_uop(OP_FMUL, R_T0, R_INF, R_A4, 8'd0);
      7'd62: u = mk_uop(OP_ADD,  R_T0, R_T0, R_A0, 8'd0);
      7'd63: u = mk_uop(OP_ADD,  R_VAL, R_T0, R_B0, 8'd0);
      default: u = mk_uop(OP_OUT, R_T0, R_LOC, R_VAL, 8'd0);
    endcase
    return u;
  endfunction

endpackage

// ===== rtl/qmcf_front.sv =====
// Input stage: registers one item and tags a non-positive quartic term.
// Depends on qmcf_pkg (item_t).
module qmcf_front import qmcf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] coef0,
  input  logic signed [31:0] coef1,
  input  logic signed [31:0] coef2,
  input  logic signed [31:0] coef3,
  input  logic signed [31:0] coef4,
  input  logic               q_full,
  output logic               enq,
  output item_t              enq_item
);

  logic  stage_valid;
  item_t stage;

  assign enq      = stage_valid && !q_full;
  assign full     = stage_valid && q_full;
  assign enq_item = stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (push && !full) begin
      stage_valid <= 1'b1;
    end else if (enq) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      stage.coef0 <= coef0;
      stage.coef1 <= coef1;
      stage.coef2 <= coef2;
      stage.coef3 <= coef3;
      stage.coef4 <= coef4;
      stage.bad   <= (coef4 <= 32'sd0);
    end
  end

endmodule

// ===== rtl/qmcf_queue.sv =====
// Short queue between the input stage and the evaluation sequencer.
// Depends on qmcf_pkg (item_t, QUEUE_DEPTH, QPTR_W).
module qmcf_queue import qmcf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  enq,
  input  item_t enq_item,
  output logic  q_full,
  input  logic  deq,
  output item_t head,
  output logic  head_valid
);

  item_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;

  assign q_full     = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) wr_ptr <= wr_ptr + 1'b1;
      if (deq) rd_ptr <= rd_ptr + 1'b1;
      if (enq && !deq) count <= count + 1'b1;
      else if (deq && !enq) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) slots[wr_ptr] <= enq_item;
  end

endmodule

// ===== rtl/qmcf_back.sv =====
// Evaluation sequencer: microcoded walk over a register file with shared
// multiplier, divider and root units, plus the result register.
// Depends on qmcf_pkg (types, codes, microcode program).
module qmcf_back import qmcf_pkg::*; #(
  parameter int FRAC_BITS       = 16,
  parameter int ROOT_ITERATIONS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [15:0]        flat_threshold,
  input  item_t              head,
  input  logic               head_valid,
  output logic               head_pop,
  output logic signed [31:0] min_location,
  output logic signed [31:0] min_value,
  output logic [1:0]         status,
  output logic               empty,
  input  logic               pop
);

  localparam int SQ_TOP = (ROOT_ITERATIONS < 48) ? ROOT_ITERATIONS : 48;
  localparam int CB_TOP = (ROOT_ITERATIONS < 40) ? ROOT_ITERATIONS : 40;

  // ceil(2^65 / 3): x / 3 == (x * RECIP3) >> 65 for any 64-bit x
  localparam logic [63:0] RECIP3 = 64'hAAAA_AAAA_AAAA_AAAB;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LOAD  = 5'b00010,
    ST_FETCH = 5'b00100,
    ST_EXEC  = 5'b01000,
    ST_WAIT  = 5'b10000
  } state_t;

  typedef struct packed {
    logic  sat;
    word_t val;
  } res_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] val;
  } res32_t;

  function automatic logic [63:0] mag(input word_t x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

  function automatic res_t mk(input logic neg, input logic [63:0] m);
    res_t        r;
    logic [63:0] mm;
    r.sat = (m > MAXV_U);
    mm    = r.sat ? MAXV_U : m;
    r.val = neg ? -$signed(mm) : $signed(mm);
    return r;
  endfunction

  function automatic res_t clamp65(input logic signed [64:0] s);
    res_t r;
    if (s > $signed({1'b0, MAXV_U})) begin
      r.sat = 1'b1; r.val = $signed(MAXV_U);
    end else if (s < -$signed({1'b0, MAXV_U})) begin
      r.sat = 1'b1; r.val = -$signed(MAXV_U);
    end else begin
      r.sat = 1'b0; r.val = s[63:0];
    end
    return r;
  endfunction

  function automatic res32_t out32(input word_t v);
    res32_t r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r.sat = 1'b1; r.val = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r.sat = 1'b1; r.val = -32'sh8000_0000;
    end else begin
      r.sat = 1'b0; r.val = v[31:0];
    end
    return r;
  endfunction

  state_t     state;
  logic [6:0] pc;
  logic [2:0] load_cnt;
  logic       sat;
  uop_t       uop;
  word_t      rf [32];
  word_t      ra_q;
  word_t      rb_q;
  logic       rf_we;
  logic [4:0] rf_wa;
  word_t      rf_wd;
  logic signed [31:0] load_coef;
  logic       out_valid;
  logic       out_free;
  res_t       alu;
  logic       alu_op;
  logic       unit_done;
  res_t       unit_res;
  res32_t     loc32;
  res32_t     val32;

  assign uop      = uop_rom(pc);
  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;
  assign loc32    = out32(ra_q);
  assign val32    = out32(rb_q);

  // ---------------- combinational ALU ----------------
  logic [67:0] muli_p;
  assign muli_p = 68'(mag(ra_q)) * 68'(rb_q == rb_q ? uop.imm[3:0] : 4'd0);

  always_comb begin
    alu = '0;
    case (uop.op)
      OP_ADD:  alu = clamp65($signed({ra_q[63], ra_q}) + $signed({rb_q[63], rb_q}));
      OP_SUB:  alu = clamp65($signed({ra_q[63], ra_q}) - $signed({rb_q[63], rb_q}));
      OP_SHR:  alu = mk(ra_q[63], mag(ra_q) >> uop.imm[5:0]);
      OP_MULI: begin
        alu = mk(ra_q[63], (muli_p[67:63] != '0) ? MAXV_U : muli_p[63:0]);
        alu.sat = alu.sat || (muli_p[67:63] != '0);
      end
      OP_NEG:  alu = '{sat: 1'b0, val: -ra_q};
      OP_MIN0: alu = '{sat: 1'b0, val: ra_q[63] ? ra_q : '0};
      default: alu = '0;
    endcase
  end

  always_comb begin
    case (uop.op)
      OP_ADD, OP_SUB, OP_SHR, OP_MULI, OP_NEG, OP_MIN0: alu_op = 1'b1;
      default: alu_op = 1'b0;
    endcase
  end

  // ---------------- multiplier: four 32x32 partial products ----------------
  // Also divides by three through the reciprocal.
  logic [63:0]  mul_a, mul_b;
  logic         mul_neg;
  logic         mul_div3;
  logic [127:0] mul_acc;
  logic [2:0]   mul_step;
  logic [63:0]  mul_pp;
  logic [127:0] mul_pp_sh;
  res_t         mul_res;

  assign mul_pp = 64'(mul_step[1] ? mul_a[63:32] : mul_a[31:0])
                * 64'(mul_step[0] ? mul_b[63:32] : mul_b[31:0]);

  always_comb begin
    case (mul_step[1:0])
      2'd0:    mul_pp_sh = {64'd0, mul_pp};
      2'd3:    mul_pp_sh = {mul_pp, 64'd0};
      default: mul_pp_sh = {32'd0, mul_pp, 32'd0};
    endcase
  end

  always_comb begin
    if (mul_div3) begin
      mul_res = mk(mul_neg, {1'b0, mul_acc[127:65]});
    end else if (mul_acc[127:64+FRAC_BITS] != '0) begin
      mul_res.sat = 1'b1;
      mul_res.val = mul_neg ? -$signed(MAXV_U) : $signed(MAXV_U);
    end else begin
      mul_res = mk(mul_neg, mul_acc[FRAC_BITS+63:FRAC_BITS]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_step <= 3'd4;
    end else if (state == ST_EXEC && (uop.op == OP_FMUL || uop.op == OP_DIV3)) begin
      mul_a    <= mag(ra_q);
      mul_b    <= (uop.op == OP_DIV3) ? RECIP3 : mag(rb_q);
      mul_neg  <= (uop.op == OP_DIV3) ? ra_q[63] : (ra_q[63] ^ rb_q[63]);
      mul_div3 <= (uop.op == OP_DIV3);
      mul_acc  <= '0;
      mul_step <= 3'd0;
    end else if (mul_step != 3'd4) begin
      mul_acc  <= mul_acc + mul_pp_sh;
      mul_step <= mul_step + 3'd1;
    end
  end

  // ---------------- divider: one quotient bit per cycle ----------------
  logic [63:0]  div_d, div_lo, div_rem, div_q;
  logic         div_neg, div_xneg, div_zero, div_ovf;
  logic [6:0]   div_cnt;
  logic [127:0] div_n_w;
  logic [63:0]  div_d_w;
  logic [64:0]  div_rem2;
  res_t         div_res;

  assign div_n_w  = {64'd0, mag(ra_q)} << FRAC_BITS;
  assign div_d_w  = mag(rb_q);
  assign div_rem2 = {div_rem, div_lo[63]};

  always_comb begin
    if (div_zero) begin
      div_res.sat = 1'b1;
      div_res.val = div_xneg ? -$signed(MAXV_U) : $signed(MAXV_U);
    end else if (div_ovf) begin
      div_res.sat = 1'b1;
      div_res.val = div_neg ? -$signed(MAXV_U) : $signed(MAXV_U);
    end else begin
      div_res = mk(div_neg, div_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (state == ST_EXEC && uop.op == OP_FDIV) begin
      div_d    <= div_d_w;
      div_lo   <= div_n_w[63:0];
      div_rem  <= div_n_w[127:64];
      div_q    <= '0;
      div_xneg <= ra_q[63];
      div_neg  <= ra_q[63] ^ rb_q[63];
      div_zero <= (div_d_w == '0);
      div_ovf  <= (div_d_w != '0) && (div_n_w[127:64] >= div_d_w);
      div_cnt  <= ((div_d_w == '0) || (div_n_w[127:64] >= div_d_w)) ? 7'd0 : 7'd64;
    end else if (div_cnt != '0) begin
      div_lo  <= {div_lo[62:0], 1'b0};
      if (div_rem2 >= {1'b0, div_d}) begin
        div_rem <= 64'(div_rem2 - {1'b0, div_d});
        div_q   <= {div_q[62:0], 1'b1};
      end else begin
        div_rem <= div_rem2[63:0];
        div_q   <= {div_q[62:0], 1'b0};
      end
      div_cnt <= div_cnt - 7'd1;
    end
  end

  // ---------------- square / cube root: one root bit per cycle ----------------
  logic [127:0] rt_n, rt_r2, rt_r3;
  logic [63:0]  rt_r;
  logic         rt_cube, rt_zero;
  logic [5:0]   rt_b;
  logic [6:0]   rt_left;
  logic [7:0]   rt_sh1, rt_sh2, rt_sh3;
  logic [127:0] rt_c2, rt_c3, rt_r1sq, rt_r1cu;
  logic         rt_take;
  res_t         rt_res;

  assign rt_sh1 = {2'b00, rt_b} + 8'd1;
  assign rt_sh2 = {1'b0, rt_b, 1'b0};
  assign rt_sh3 = {2'b00, rt_b} + {1'b0, rt_b, 1'b0};
  assign rt_c2  = rt_r2 + ({64'd0, rt_r} << rt_sh1) + (128'd1 << rt_sh2);
  assign rt_c3  = rt_r3 + ((rt_r2 + (rt_r2 << 1)) << rt_b)
                + (({64'd0, rt_r} + ({64'd0, rt_r} << 1)) << rt_sh2) + (128'd1 << rt_sh3);
  assign rt_take = rt_cube ? (rt_c3 <= rt_n) : (rt_c2 <= rt_n);
  assign rt_r1sq = rt_r2 + ({64'd0, rt_r} << 1) + 128'd1;
  assign rt_r1cu = rt_r3 + rt_r2 + (rt_r2 << 1) + {64'd0, rt_r}
                 + ({64'd0, rt_r} << 1) + 128'd1;

  always_comb begin
    rt_res.val = $signed(rt_r);
    rt_res.sat = !rt_zero && (rt_cube ? (rt_r1cu <= rt_n) : (rt_r1sq <= rt_n));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rt_left <= '0;
    end else if (state == ST_EXEC && (uop.op == OP_SQRT || uop.op == OP_CBRT)) begin
      rt_cube <= (uop.op == OP_CBRT);
      rt_zero <= (ra_q <= 64'sd0);
      rt_n    <= (uop.op == OP_CBRT) ? ({64'd0, ra_q} << (2*FRAC_BITS))
                                     : ({64'd0, ra_q} << FRAC_BITS);
      rt_r    <= '0;
      rt_r2   <= '0;
      rt_r3   <= '0;
      rt_b    <= (uop.op == OP_CBRT) ? 6'(CB_TOP-1) : 6'(SQ_TOP-1);
      if (ra_q <= 64'sd0) rt_left <= '0;
      else rt_left <= (uop.op == OP_CBRT) ? 7'(CB_TOP) : 7'(SQ_TOP);
    end else if (rt_left != '0) begin
      if (rt_take) begin
        rt_r  <= rt_r | (64'd1 << rt_b);
        rt_r2 <= rt_c2;
        rt_r3 <= rt_c3;
      end
      rt_b    <= rt_b - 6'd1;
      rt_left <= rt_left - 7'd1;
    end
  end

  // ---------------- unit completion ----------------
  always_comb begin
    case (uop.op)
      OP_FMUL, OP_DIV3: begin unit_done = (mul_step == 3'd4); unit_res = mul_res; end
      OP_FDIV:          begin unit_done = (div_cnt == '0);    unit_res = div_res; end
      OP_SQRT, OP_CBRT: begin unit_done = (rt_left == '0);    unit_res = rt_res;  end
      default:          begin unit_done = 1'b1;               unit_res = '0;      end
    endcase
  end

  // ---------------- register file ----------------
  always_comb begin
    case (load_cnt)
      3'd0:    load_coef = head.coef0;
      3'd1:    load_coef = head.coef1;
      3'd2:    load_coef = head.coef2;
      3'd3:    load_coef = head.coef3;
      default: load_coef = head.coef4;
    endcase
  end

  always_comb begin
    rf_we = 1'b0;
    rf_wa = uop.rd;
    rf_wd = unit_res.val;
    case (state)
      ST_LOAD: begin
        rf_we = 1'b1;
        rf_wa = {2'b00, load_cnt};
        rf_wd = {{32{load_coef[31]}}, load_coef};
      end
      ST_EXEC: begin
        rf_we = alu_op;
        rf_wd = alu.val;
      end
      ST_WAIT: rf_we = unit_done;
      default: rf_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rf_we) rf[rf_wa] <= rf_wd;
    ra_q <= rf[uop.ra];
    rb_q <= rf[uop.rb];
  end

  assign head_pop = (state == ST_IDLE && head_valid && head.bad && out_free)
                 || (state == ST_LOAD && load_cnt == 3'd4);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      pc        <= '0;
      load_cnt  <= '0;
      sat       <= 1'b0;
    end else begin
      if (pop && out_valid) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (head_valid && head.bad) begin
            if (out_free) begin
              min_location <= '0;
              min_value    <= '0;
              status       <= STAT_BAD_LEAD;
              out_valid    <= 1'b1;
            end
          end else if (head_valid) begin
            load_cnt <= '0;
            state    <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          load_cnt <= load_cnt + 3'd1;
          if (load_cnt == 3'd4) begin
            pc    <= '0;
            sat   <= 1'b0;
            state <= ST_FETCH;
          end
        end
        ST_FETCH: state <= ST_EXEC;
        ST_EXEC: begin
          case (uop.op)
            OP_ADD, OP_SUB, OP_SHR, OP_MULI, OP_NEG, OP_MIN0: begin
              sat   <= sat | alu.sat;
              pc    <= pc + 7'd1;
              state <= ST_FETCH;
            end
            OP_FMUL, OP_FDIV, OP_DIV3, OP_SQRT, OP_CBRT: state <= ST_WAIT;
            OP_JFLAT: begin
              pc    <= (mag(ra_q) <= {48'd0, flat_threshold}) ? uop.imm[6:0] : pc + 7'd1;
              state <= ST_FETCH;
            end
            OP_JMP: begin
              pc    <= uop.imm[6:0];
              state <= ST_FETCH;
            end
            OP_JNEG: begin
              if (!ra_q[63]) begin
                pc    <= pc + 7'd1;
                state <= ST_FETCH;
              end else if (out_free) begin
                min_location <= '0;
                min_value    <= '0;
                status       <= STAT_NEG_DISC;
                out_valid    <= 1'b1;
                state        <= ST_IDLE;
              end
            end
            OP_OUT: begin
              if (out_free) begin
                min_location <= loc32.val;
                min_value    <= val32.val;
                status       <= (sat || loc32.sat || val32.sat) ? STAT_SAT : STAT_OK;
                out_valid    <= 1'b1;
                state        <= ST_IDLE;
              end
            end
            default: state <= ST_IDLE;
          endcase
        end
        ST_WAIT: begin
          if (unit_done) begin
            sat   <= sat | unit_res.sat;
            pc    <= pc + 7'd1;
            state <= ST_FETCH;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------- checks ----------------
  a_pop_needs_head: assert property (@(posedge clk) disable iff (rst)
    head_pop |-> head_valid) else $error("queue popped while empty");

  a_bad_lead_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STAT_BAD_LEAD) |-> (min_location == 0 && min_value == 0))
    else $error("bad-lead result carries nonzero payload");

  a_wait_holds_pc: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WAIT && !unit_done) |=> (state == ST_WAIT && $stable(pc)))
    else $error("sequencer left a busy unit");

  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    pc <= PC_LAST) else $error("program counter past the end");

endmodule

// ===== rtl/quartic_minimum_closed_form.sv =====
// Top level of the quartic minimum block: threshold register, input stage,
// item queue and evaluation sequencer. Depends on qmcf_pkg and the qmcf_* modules.
//
// Finds the minimum of p(x) = coef4 x^4 + coef3 x^3 + coef2 x^2 + coef1 x + coef0
// (signed fixed point, FRAC_BITS fraction bits) by the closed-form scheme: depressed
// quartic terms, then a cube-root branch or, when |b1| <= flat_threshold, the
// symmetric branch. Internal arithmetic is saturating 64-bit fixed point; any
// saturation reports status 3, a non-positive coef4 status 1 and a negative
// discriminant status 2 (both with zero location and value). Both sides look like
// a queue: push/full in, empty/pop out. Items buffer in a four-deep queue while
// the sequencer works, and a finished result sits in an output register without
// holding up the next item. The one shared sequencer evaluates one item at a time; its
// divider resolves one quotient bit per cycle and its root unit one root bit per
// cycle. An item with a non-positive coef4 skips the program and leaves straight
// from idle once the output register is free. Write flat_threshold only while idle.
module quartic_minimum_closed_form import qmcf_pkg::*; #(
  parameter int FRAC_BITS       = 16,
  parameter int ROOT_ITERATIONS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [15:0]        cfg_data,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] coef0,
  input  logic signed [31:0] coef1,
  input  logic signed [31:0] coef2,
  input  logic signed [31:0] coef3,
  input  logic signed [31:0] coef4,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] min_location,
  output logic signed [31:0] min_value,
  output logic [1:0]         status
);

  logic [15:0] flat_threshold;
  logic        q_full;
  logic        enq;
  item_t       enq_item;
  item_t       head;
  logic        head_valid;
  logic        head_pop;

  // hold the branch threshold; the user writes it between transactions only, unchecked
  always_ff @(posedge clk) begin
    if (rst) begin
      flat_threshold <= '0;
    end else if (cfg_write) begin
      flat_threshold <= cfg_data;
    end
  end

  // register and classify each incoming transaction
  qmcf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .coef0    (coef0),
    .coef1    (coef1),
    .coef2    (coef2),
    .coef3    (coef3),
    .coef4    (coef4),
    .q_full   (q_full),
    .enq      (enq),
    .enq_item (enq_item)
  );

  // decouple intake from evaluation
  qmcf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .enq        (enq),
    .enq_item   (enq_item),
    .q_full     (q_full),
    .deq        (head_pop),
    .head       (head),
    .head_valid (head_valid)
  );

  // evaluate and present results
  qmcf_back #(
    .FRAC_BITS       (FRAC_BITS),
    .ROOT_ITERATIONS (ROOT_ITERATIONS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .flat_threshold (flat_threshold),
    .head           (head),
    .head_valid     (head_valid),
    .head_pop       (head_pop),
    .min_location   (min_location),
    .min_value      (min_value),
    .status         (status),
    .empty          (empty),
    .pop            (pop)
  );

endmodule
